/* src/lzd_pkg.sv */
`default_nettype none

package lzd_pkg;

    // history window, fixed by the format
    localparam int HIST_DEPTH = 4096;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    localparam int SIZE_BITS_DEF = 24;
    localparam int CFG_W         = 24;

    localparam int LEN_W      = 5;      // copy length 3..18
    localparam int LEN_BIAS   = 3;
    localparam int FLAG_W     = 32;
    localparam int BITS_W     = 6;      // 0..32 flag bits left
    localparam int DIST_W     = HIST_AW + 1;

    typedef enum logic [1:0] {
        KIND_FLAG = 2'd0,
        KIND_LIT  = 2'd1,
        KIND_REF  = 2'd2,
        KIND_DONE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_KIND = 2'd1,
        ERR_DIST = 2'd2,
        ERR_RSVD = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_COPY
    } state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        kind_t      next_kind;
        err_t       error;
    } lzd_result_t;

    typedef struct packed {
        logic               en;
        logic [HIST_AW-1:0] addr;
        logic [7:0]         data;
    } hist_wr_t;

    typedef struct packed {
        logic               en;
        logic [HIST_AW-1:0] addr;
    } hist_rd_t;

    // token the decoder asks for, given the state it will be in
    function automatic kind_t next_want(input logic at_end, input logic no_bits,
                                        input logic top_bit);
        kind_t k;
        if (at_end) begin
            k = KIND_DONE;
        end else if (no_bits) begin
            k = KIND_FLAG;
        end else if (top_bit) begin
            k = KIND_LIT;
        end else begin
            k = KIND_REF;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

/* src/lz_flag_backref_decompressor_unit.sv */
// MIO0-style LZ decompressor.
// Input channel s_*: one token per item. s_tuser is the token kind (0 flag word,
// 1 literal, 2 back-reference); s_tdata is the payload. Send the kind that the
// last result asked for in next_kind; a wrong kind returns error 1 and is dropped.
// Output channel m_*: one item per emitted byte, or a single status item for a
// flag word or an error. m_tlast marks the last item caused by a token.
// Config: cfg_wr_en/cfg_wr_data set the output size and restart decoding; write
// only while idle. The 4096-byte history keeps its contents across restarts.
// Timing: a token is taken in the idle cycle and decoded in the next one. Flag,
// literal and error tokens give their item from the decode state; a new token is
// taken only back in idle. A back-reference issues its first read in decode; the
// history RAM has one read and one write port and the copy moves one byte per
// cycle through it unless the output stalls, with forwarding for distance-1 copies.
// A one-entry output register decouples the result side; while it is full and
// m_tready is low the copy pauses with its pending RAM read held; nothing is lost.
// Reset (aresetn low, synchronous) clears the decoder: output size 0, so the
// first result reports finished until a size is written.
`default_nettype none

module lz_flag_backref_decompressor_unit
    import lzd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_W-1:0]  cfg_wr_data,   // output_size
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,       // [31:0] payload
    input  wire logic [1:0]        s_tuser,       // [1:0] kind
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,       // [7:0] out_byte, [9:8] next_kind,
                                                  // [11:10] error, rest zero
    output logic [0:0]             m_tuser,       // [0] byte_valid
    output logic                   m_tlast        // last
);

    lzd_result_t res;
    logic        res_valid;
    logic        res_ready;
    lzd_result_t out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    lzd_engine #(
        .SIZE_BITS (SIZE_BITS)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (kind_t'(s_tuser)),
        .in_payload  (s_tdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // output slot takes a new item when empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (res_ready) begin
            out_valid_next = res_valid;
            if (res_valid) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.error, out_reg.next_kind, out_reg.out_byte};
    assign m_tuser  = out_reg.byte_valid;
    assign m_tlast  = out_reg.last;

`ifndef NO_ASSERTIONS
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output item changed while stalled");

    a_clean_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[7:0] == 8'd0 && m_tlast))
        else $error("status item carries a byte or is not last");

    a_error_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[11:10] != 2'd0) |-> !m_tuser[0])
        else $error("error item flagged as byte");
`endif

endmodule

`default_nettype wire

/* src/lzd_hist_ram.sv */
`default_nettype none

module lzd_hist_ram
    import lzd_pkg::*;
(
    input  wire logic       aclk,
    input  wire hist_wr_t   wr,
    input  wire hist_rd_t   rd,
    output logic [7:0]      rd_data
);

    logic [7:0] mem [HIST_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read-first; data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/lzd_engine.sv */
`default_nettype none

module lzd_engine
    import lzd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_W-1:0]  cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire kind_t             in_kind,
    input  wire logic [FLAG_W-1:0] in_payload,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output lzd_result_t            res
);

    state_t                state_reg, state_next;
    kind_t                 kind_reg, kind_next;
    logic [FLAG_W-1:0]     payload_reg, payload_next;
    logic [SIZE_BITS-1:0]  bytes_out_reg, bytes_out_next;
    logic [SIZE_BITS-1:0]  size_reg, size_next;
    logic [FLAG_W-1:0]     flag_bits_reg, flag_bits_next;
    logic [BITS_W-1:0]     bits_left_reg, bits_left_next;
    logic [HIST_AW-1:0]    src_reg, src_next;
    logic [LEN_W-1:0]      cnt_reg, cnt_next;
    kind_t                 nk_reg, nk_next;
    logic                  fwd_hit_reg, fwd_hit_next;
    logic [7:0]            fwd_data_reg, fwd_data_next;

    hist_wr_t              wr;
    hist_rd_t              rd;
    logic [7:0]            ram_data;
    logic [7:0]            rd_byte;

    logic [31:0]           cfg_ext;
    kind_t                 want;
    logic                  err_kind;
    logic [LEN_W-1:0]      len;
    logic [DIST_W-1:0]     ref_dist;
    logic                  dist_far;
    logic [SIZE_BITS-1:0]  remain;
    logic                  ref_end;
    logic [LEN_W-1:0]      ref_n;
    logic [HIST_AW-1:0]    src0;
    kind_t                 nk_lit;
    kind_t                 nk_ref;

    lzd_hist_ram u_hist (
        .aclk    (aclk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (ram_data)
    );

    assign cfg_ext = {{(32 - CFG_W){1'b0}}, cfg_wr_data};

    // a dist-1 copy reads the entry written in the same cycle
    assign rd_byte = fwd_hit_reg ? fwd_data_reg : ram_data;

    always_comb begin
        want     = next_want(bytes_out_reg == size_reg, bits_left_reg == '0,
                             flag_bits_reg[FLAG_W-1]);
        err_kind = (kind_reg != want) || (want == KIND_DONE);
        len      = LEN_W'(payload_reg[15:12]) + LEN_W'(LEN_BIAS);
        ref_dist = DIST_W'(payload_reg[HIST_AW-1:0]) + DIST_W'(1);
        dist_far = SIZE_BITS'(ref_dist) > bytes_out_reg;
        remain   = size_reg - bytes_out_reg;
        ref_end  = remain <= SIZE_BITS'(len);
        ref_n    = ref_end ? remain[LEN_W-1:0] : len;
        src0     = bytes_out_reg[HIST_AW-1:0] - ref_dist[HIST_AW-1:0];
        nk_lit   = next_want(bytes_out_reg + SIZE_BITS'(1) == size_reg,
                             bits_left_reg == BITS_W'(1), flag_bits_reg[FLAG_W-2]);
        nk_ref   = next_want(ref_end, bits_left_reg == BITS_W'(1),
                             flag_bits_reg[FLAG_W-2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            bytes_out_reg <= '0;
            size_reg      <= '0;
            flag_bits_reg <= '0;
            bits_left_reg <= '0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            bytes_out_reg <= bytes_out_next;
            size_reg      <= size_next;
            flag_bits_reg <= flag_bits_next;
            bits_left_reg <= bits_left_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        payload_reg  <= payload_next;
        src_reg      <= src_next;
        nk_reg       <= nk_next;
        fwd_hit_reg  <= fwd_hit_next;
        fwd_data_reg <= fwd_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        payload_next   = payload_reg;
        bytes_out_next = bytes_out_reg;
        size_next      = size_reg;
        flag_bits_next = flag_bits_reg;
        bits_left_next = bits_left_reg;
        src_next       = src_reg;
        cnt_next       = cnt_reg;
        nk_next        = nk_reg;
        fwd_hit_next   = fwd_hit_reg;
        fwd_data_next  = fwd_data_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        res            = '0;
        wr             = '0;
        rd             = '0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    kind_next    = in_kind;
                    payload_next = in_payload;
                    state_next   = ST_DECODE;
                end
            end

            ST_DECODE: begin
                if (err_kind) begin
                    res_valid     = 1'b1;
                    res.last      = 1'b1;
                    res.next_kind = want;
                    res.error     = ERR_KIND;
                    if (res_ready) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    unique case (kind_reg)
                        KIND_FLAG: begin
                            res_valid     = 1'b1;
                            res.last      = 1'b1;
                            res.next_kind = payload_reg[FLAG_W-1] ? KIND_LIT : KIND_REF;
                            if (res_ready) begin
                                flag_bits_next = payload_reg;
                                bits_left_next = BITS_W'(FLAG_W);
                                state_next     = ST_IDLE;
                            end
                        end
                        KIND_LIT: begin
                            res_valid      = 1'b1;
                            res.out_byte   = payload_reg[7:0];
                            res.byte_valid = 1'b1;
                            res.last       = 1'b1;
                            res.next_kind  = nk_lit;
                            if (res_ready) begin
                                wr.en          = 1'b1;
                                wr.addr        = bytes_out_reg[HIST_AW-1:0];
                                wr.data        = payload_reg[7:0];
                                bytes_out_next = bytes_out_reg + SIZE_BITS'(1);
                                flag_bits_next = flag_bits_reg << 1;
                                bits_left_next = bits_left_reg - BITS_W'(1);
                                state_next     = ST_IDLE;
                            end
                        end
                        KIND_REF: begin
                            if (dist_far) begin
                                res_valid     = 1'b1;
                                res.last      = 1'b1;
                                res.next_kind = want;
                                res.error     = ERR_DIST;
                                if (res_ready) begin
                                    state_next = ST_IDLE;
                                end
                            end else begin
                                // flag bit is used up now; next_kind is fixed for the copy
                                flag_bits_next = flag_bits_reg << 1;
                                bits_left_next = bits_left_reg - BITS_W'(1);
                                cnt_next       = ref_n;
                                nk_next        = nk_ref;
                                rd.en          = 1'b1;
                                rd.addr        = src0;
                                src_next       = src0 + HIST_AW'(1);
                                fwd_hit_next   = 1'b0;
                                state_next     = ST_COPY;
                            end
                        end
                        KIND_DONE: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_COPY: begin
                res_valid      = 1'b1;
                res.out_byte   = rd_byte;
                res.byte_valid = 1'b1;
                res.last       = cnt_reg == LEN_W'(1);
                res.next_kind  = nk_reg;
                if (res_ready) begin
                    wr.en          = 1'b1;
                    wr.addr        = bytes_out_reg[HIST_AW-1:0];
                    wr.data        = rd_byte;
                    bytes_out_next = bytes_out_reg + SIZE_BITS'(1);
                    cnt_next       = cnt_reg - LEN_W'(1);
                    if (cnt_reg == LEN_W'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd.en         = 1'b1;
                        rd.addr       = src_reg;
                        src_next      = src_reg + HIST_AW'(1);
                        fwd_hit_next  = src_reg == bytes_out_reg[HIST_AW-1:0];
                        fwd_data_next = rd_byte;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // restart on a size write (the user must write it only while idle; this block does not enforce it)
        if (cfg_wr_en) begin
            size_next      = cfg_ext[SIZE_BITS-1:0];
            bytes_out_next = '0;
            flag_bits_next = '0;
            bits_left_next = '0;
        end
    end

`ifndef NO_ASSERTIONS
    a_bytes_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_out_reg <= size_reg)
        else $error("bytes_out passed output_size");

    a_copy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COPY |-> cnt_reg != '0)
        else $error("copy state with no bytes left");

    a_copy_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY && res_ready && cnt_reg == LEN_W'(1)) |=> state_reg == ST_IDLE)
        else $error("copy did not end after its last byte");

    a_write_on_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> (res_valid && res_ready && res.byte_valid))
        else $error("history written without an emitted byte");
`endif

endmodule

`default_nettype wire
